// File: rtl/core/track_confirm_coast_gate_assert.svh
// Assertion macros for the track confirmation and coast gate.
// Included by the top level; no other dependencies.
`ifndef TRACK_CONFIRM_COAST_GATE_ASSERT_SVH
`define TRACK_CONFIRM_COAST_GATE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TCCG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define TCCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/tccg_pkg.sv
// Shared types and constants for the track confirmation and coast gate.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tccg_pkg;

  typedef enum logic [1:0] {
    ST_LOST      = 2'd0,
    ST_DETECTING = 2'd1,
    ST_TRACKING  = 2'd2,
    ST_TEMP_LOST = 2'd3
  } tccg_state_t;

  localparam int unsigned IN_W       = 72;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_FRAMES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_LIMIT_NORMAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_LIMIT_OUTPOST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR_SPEED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGULAR_SPEED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAIL_RATE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_WINDOW_SIZE    = 3'd6;

  localparam logic [7:0]  RST_CONFIRM_FRAMES      = 8'd3;
  localparam logic [9:0]  RST_COAST_LIMIT_NORMAL  = 10'd50;
  localparam logic [9:0]  RST_COAST_LIMIT_OUTPOST = 10'd100;
  localparam logic [14:0] RST_MAX_LINEAR_SPEED    = 15'd1280;
  localparam logic [14:0] RST_MAX_ANGULAR_SPEED   = 15'd5120;
  localparam logic [8:0]  RST_MAX_FAIL_RATE       = 9'd128;
  localparam logic [7:0]  RST_FAIL_WINDOW_SIZE    = 8'd20;
  localparam logic [29:0] RST_SPEED_LIMIT_SQ      = 30'd1638400;

  localparam logic [7:0]  DETECT_MAX = 8'd255;
  localparam logic [10:0] COAST_MAX  = 11'd2047;

  // Per-frame flags that drive the state machine
  typedef struct packed {
    logic       frame_gap_large;
    logic       match_found;
    logic       target_is_outpost;
    logic       diverged;
    logic [7:0] fail_window_count;
    logic       innovation_failed;
    logic       match_refused;
    logic       predict_only;
  } tccg_flags_t;

  typedef struct packed {
    logic [7:0] confirm_frames;
    logic [9:0] coast_limit_normal;
    logic [9:0] coast_limit_outpost;
    logic [7:0] fail_window_size;
  } tccg_track_cfg_t;

  // Packed so that track_state lands in the lowest bits of the output beat
  typedef struct packed {
    logic [10:0] coast_count;
    logic [7:0]  warmup_count;
    logic        gate_open;
    logic        init_rejected;
    logic        target_valid;
    tccg_state_t track_state;
  } tccg_result_t;

endpackage

`default_nettype wire

// File: rtl/core/tccg_kin_check.sv
// Kinematic part of the control gate: squared speed, spin rate and failure rate.
// Depends on tccg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccg_kin_check (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic signed [15:0] vel_x,
  input  wire logic signed [15:0] vel_y,
  input  wire logic signed [15:0] ang_vel,
  input  wire logic        [8:0]  fail_rate,
  input  wire logic        [14:0] max_angular_speed,
  input  wire logic        [8:0]  max_fail_rate,
  input  wire logic        [29:0] speed_limit_sq,
  output logic                    kin_bad
);
  import tccg_pkg::*;

  logic signed [31:0] prod_x;
  logic signed [31:0] prod_y;
  logic        [15:0] ang_abs;
  logic        [30:0] sq_x;
  logic        [30:0] sq_y;
  logic               ang_over;
  logic               rate_over;
  logic        [31:0] speed_sq;

  always_comb begin
    prod_x  = vel_x * vel_x;
    prod_y  = vel_y * vel_y;
    // most negative value maps to 0x8000, which is its true magnitude
    ang_abs = ang_vel[15] ? (~$unsigned(ang_vel) + 16'd1) : $unsigned(ang_vel);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sq_x      <= prod_x[30:0];
      sq_y      <= prod_y[30:0];
      ang_over  <= ang_abs > {1'b0, max_angular_speed};
      rate_over <= fail_rate > max_fail_rate;
    end
  end

  assign speed_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign kin_bad  = (speed_sq > {2'b00, speed_limit_sq}) || ang_over || rate_over;

endmodule

`default_nettype wire

// File: rtl/core/tccg_track_fsm.sv
// Track state machine, gate latch and result register.
// Depends on tccg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccg_track_fsm (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire tccg_pkg::tccg_flags_t     flags,
  input  wire logic                      kin_bad,
  input  wire tccg_pkg::tccg_track_cfg_t cfg,
  output tccg_pkg::tccg_result_t         result
);
  import tccg_pkg::*;

  tccg_state_t  state;
  tccg_state_t  state_next;
  logic [7:0]   detect_count;
  logic [7:0]   detect_count_next;
  logic [10:0]  coast_count;
  logic [10:0]  coast_count_next;
  logic         gate_rejected;
  logic         gate_rejected_next;
  tccg_result_t result_next;

  tccg_state_t  st_gap;
  logic [9:0]   coast_sel;
  logic [10:0]  win_x5;
  logic [10:0]  win_lim;
  logic         init_rej;
  logic         valid;
  logic [7:0]   warm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOST;
      detect_count  <= '0;
      coast_count   <= '0;
      gate_rejected <= 1'b0;
    end else if (load) begin
      state         <= state_next;
      detect_count  <= detect_count_next;
      coast_count   <= coast_count_next;
      gate_rejected <= gate_rejected_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  always_comb begin
    st_gap             = (state != ST_LOST && flags.frame_gap_large) ? ST_LOST : state;
    init_rej           = (st_gap == ST_DETECTING) && !flags.match_found;
    coast_sel          = flags.target_is_outpost ? cfg.coast_limit_outpost
                                                 : cfg.coast_limit_normal;
    state_next         = st_gap;
    detect_count_next  = detect_count;
    coast_count_next   = coast_count;
    gate_rejected_next = gate_rejected;
    valid              = 1'b0;

    unique case (st_gap)
      ST_LOST: begin
        if (flags.match_found) begin
          state_next        = ST_DETECTING;
          detect_count_next = 8'd1;
        end
      end
      ST_DETECTING: begin
        if (flags.match_found) begin
          if (detect_count < DETECT_MAX) detect_count_next = detect_count + 8'd1;
          if (detect_count_next >= cfg.confirm_frames) state_next = ST_TRACKING;
        end else begin
          detect_count_next = '0;
          state_next        = ST_LOST;
        end
      end
      ST_TRACKING: begin
        if (flags.match_found) begin
          coast_count_next = '0;
        end else begin
          coast_count_next = 11'd1;
          state_next       = ST_TEMP_LOST;
        end
      end
      ST_TEMP_LOST: begin
        if (flags.match_found) begin
          coast_count_next = '0;
          state_next       = ST_TRACKING;
        end else begin
          if (coast_count < COAST_MAX) coast_count_next = coast_count + 11'd1;
          if (coast_count_next > {1'b0, coast_sel}) state_next = ST_LOST;
        end
      end
      default: state_next = ST_LOST;
    endcase

    // bad window when count >= 0.4 * window size, i.e. 5 * count >= 2 * size
    win_x5  = {1'b0, flags.fail_window_count, 2'b00} + {3'b000, flags.fail_window_count};
    win_lim = {2'b00, cfg.fail_window_size, 1'b0};

    if (state_next != ST_LOST && flags.diverged) begin
      state_next = ST_LOST;
    end else if (win_x5 >= win_lim) begin
      state_next = ST_LOST;
    end else if (state_next == ST_TRACKING || state_next == ST_TEMP_LOST) begin
      gate_rejected_next = flags.innovation_failed
                        || (flags.match_refused
                            && !(state_next == ST_TEMP_LOST && flags.predict_only))
                        || kin_bad;
      valid = !gate_rejected_next;
    end

    unique case (state_next)
      ST_DETECTING: warm = detect_count_next;
      ST_TRACKING:  warm = cfg.confirm_frames;
      default:      warm = '0;
    endcase

    result_next.track_state   = state_next;
    result_next.target_valid  = valid;
    result_next.init_rejected = init_rej;
    result_next.gate_open     = !gate_rejected_next;
    result_next.warmup_count  = warm;
    result_next.coast_count   = coast_count_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/track_confirm_coast_gate.sv
// Top level: configuration registers, input stage and pipeline flow control.
// Depends on tccg_pkg, tccg_kin_check, tccg_track_fsm and the assertion header.
//
// Channel   Dir  Bits  Contents
// s_axis    in   72    frame flags, velocities, spin rate, failure rate
// m_axis    out  24    track state, target flags, warmup and coast counts
// cfg       in   3+15  register index and write data, no read-back
//
// One beat per cycle sustained while m_axis_tready is high. A beat passes the input
// register, then one registered stage shared by the squares and the spin-rate and
// failure-rate compares, then the state and result registers. Reset clears all valid
// bits and the track state; the block accepts a beat in the first cycle after reset.
// An output stall reaches s_axis_tready combinationally once every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module track_confirm_coast_gate (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [0] frame_gap_large, [1] match_found, [2] target_is_outpost, [3] diverged,
  // [11:4] fail_window_count, [12] innovation_failed, [13] match_refused,
  // [14] predict_only, [30:15] vel_x, [46:31] vel_y, [62:47] ang_vel,
  // [71:63] fail_rate
  input  wire logic [tccg_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [1:0] track_state, [2] target_valid, [3] init_rejected, [4] gate_open,
  // [12:5] warmup_count, [23:13] coast_count
  output logic [tccg_pkg::OUT_W-1:0]              m_axis_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tccg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tccg_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
  import tccg_pkg::*;

  `include "track_confirm_coast_gate_assert.svh"

  logic [7:0]  confirm_frames;
  logic [9:0]  coast_limit_normal;
  logic [9:0]  coast_limit_outpost;
  logic [14:0] max_linear_speed;
  logic [14:0] max_angular_speed;
  logic [8:0]  max_fail_rate;
  logic [7:0]  fail_window_size;
  logic [29:0] speed_limit_sq;
  logic [29:0] speed_limit_sq_next;

  logic            s1_valid;
  logic            s2_valid;
  logic [IN_W-1:0] s1_data;
  tccg_flags_t     s1_flags;
  tccg_flags_t     s2_flags;
  logic            out_free;
  logic            s2_free;
  logic            load1;
  logic            load2;
  logic            load3;
  logic            kin_bad;
  tccg_track_cfg_t track_cfg;
  tccg_result_t    result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_frames      <= RST_CONFIRM_FRAMES;
      coast_limit_normal  <= RST_COAST_LIMIT_NORMAL;
      coast_limit_outpost <= RST_COAST_LIMIT_OUTPOST;
      max_linear_speed    <= RST_MAX_LINEAR_SPEED;
      max_angular_speed   <= RST_MAX_ANGULAR_SPEED;
      max_fail_rate       <= RST_MAX_FAIL_RATE;
      fail_window_size    <= RST_FAIL_WINDOW_SIZE;
      speed_limit_sq      <= RST_SPEED_LIMIT_SQ;
    end else begin
      speed_limit_sq <= speed_limit_sq_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_CONFIRM_FRAMES:      confirm_frames      <= cfg_wr_data[7:0];
          CFG_COAST_LIMIT_NORMAL:  coast_limit_normal  <= cfg_wr_data[9:0];
          CFG_COAST_LIMIT_OUTPOST: coast_limit_outpost <= cfg_wr_data[9:0];
          CFG_MAX_LINEAR_SPEED:    max_linear_speed    <= cfg_wr_data[14:0];
          CFG_MAX_ANGULAR_SPEED:   max_angular_speed   <= cfg_wr_data[14:0];
          CFG_MAX_FAIL_RATE:       max_fail_rate       <= cfg_wr_data[8:0];
          CFG_FAIL_WINDOW_SIZE:    fail_window_size    <= cfg_wr_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Squared limit follows next cycle; the user writes only when idle (not enforced)
  assign speed_limit_sq_next = max_linear_speed * max_linear_speed;

  // Flow control: each stage advances when the one after it is empty or moving
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign load3         = s2_valid && out_free;
  assign s2_free       = !s2_valid || out_free;
  assign load2         = s1_valid && s2_free;
  assign s_axis_tready = !s1_valid || s2_free;
  assign load1         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      s1_valid      <= load1 || (s1_valid && !load2);
      s2_valid      <= load2 || (s2_valid && !load3);
      m_axis_tvalid <= load3 || (m_axis_tvalid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (load1) s1_data <= s_axis_tdata;
    if (load2) s2_flags <= s1_flags;
  end

  always_comb begin
    s1_flags.frame_gap_large   = s1_data[0];
    s1_flags.match_found       = s1_data[1];
    s1_flags.target_is_outpost = s1_data[2];
    s1_flags.diverged          = s1_data[3];
    s1_flags.fail_window_count = s1_data[11:4];
    s1_flags.innovation_failed = s1_data[12];
    s1_flags.match_refused     = s1_data[13];
    s1_flags.predict_only      = s1_data[14];
  end

  assign track_cfg.confirm_frames      = confirm_frames;
  assign track_cfg.coast_limit_normal  = coast_limit_normal;
  assign track_cfg.coast_limit_outpost = coast_limit_outpost;
  assign track_cfg.fail_window_size    = fail_window_size;

  tccg_kin_check u_kin (
    .clk               (clk),
    .load              (load2),
    .vel_x             ($signed(s1_data[30:15])),
    .vel_y             ($signed(s1_data[46:31])),
    .ang_vel           ($signed(s1_data[62:47])),
    .fail_rate         (s1_data[71:63]),
    .max_angular_speed (max_angular_speed),
    .max_fail_rate     (max_fail_rate),
    .speed_limit_sq    (speed_limit_sq),
    .kin_bad           (kin_bad)
  );

  tccg_track_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .load    (load3),
    .flags   (s2_flags),
    .kin_bad (kin_bad),
    .cfg     (track_cfg),
    .result  (result)
  );

  assign m_axis_tdata = result;

  `TCCG_ASSERT_NOW(a_valid_needs_track, clk, rst,
    m_axis_tvalid && result.target_valid,
    result.track_state == ST_TRACKING || result.track_state == ST_TEMP_LOST,
    "target emitted outside tracking or coasting")

  `TCCG_ASSERT_NOW(a_valid_needs_safe, clk, rst,
    m_axis_tvalid && result.target_valid, result.gate_open,
    "target emitted while gate rejects")

  `TCCG_ASSERT_NOW(a_warmup_state, clk, rst,
    m_axis_tvalid && result.warmup_count != 8'd0,
    result.track_state == ST_DETECTING || result.track_state == ST_TRACKING,
    "warmup count nonzero outside detecting or tracking")

  `TCCG_ASSERT_NEXT(a_idle_latency, clk, rst,
    load1 && !s1_valid && !s2_valid && !m_axis_tvalid, ##2 m_axis_tvalid,
    "beat through empty pipeline not delivered in three cycles")

endmodule

`default_nettype wire

// File: sim/tb_track_confirm_coast_gate.sv
// Self-checking bench for track_confirm_coast_gate: track life cycle, coasting,
// drop conditions and the control gate, checked beat by beat against a local model.
// Depends on tccg_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_track_confirm_coast_gate;
  import tccg_pkg::*;

  // Input beat laid out as on s_axis_tdata, lowest field last
  typedef struct packed {
    logic [8:0]  fail_rate;
    logic [15:0] ang_vel;
    logic [15:0] vel_y;
    logic [15:0] vel_x;
    logic        predict_only;
    logic        match_refused;
    logic        innovation_failed;
    logic [7:0]  fail_window_count;
    logic        diverged;
    logic        target_is_outpost;
    logic        match_found;
    logic        frame_gap_large;
  } frame_t;

  typedef struct packed {
    logic [7:0]  confirm_frames;
    logic [9:0]  coast_normal;
    logic [9:0]  coast_outpost;
    logic [14:0] lin_speed;
    logic [14:0] ang_speed;
    logic [8:0]  fail_rate_max;
    logic [7:0]  window;
  } gate_cfg_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  // Track model state and its copy of the registers
  tccg_state_t trk_state;
  logic [7:0]  detect_cnt;
  logic [10:0] coast_cnt;
  logic [9:0]  coast_limit_now;
  logic        gate_rej;
  gate_cfg_t   model_cfg;

  tccg_result_t pending_results[$];
  tccg_result_t seen_result;
  tccg_result_t want_result;
  int unsigned  mismatch_count = 0;
  int unsigned  send_gap_pct = 0;
  int unsigned  recv_stall_pct = 0;

  always #2 clk = ~clk;

  track_confirm_coast_gate dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  function automatic gate_cfg_t reset_cfg();
    gate_cfg_t c;
    c.confirm_frames = RST_CONFIRM_FRAMES;
    c.coast_normal   = RST_COAST_LIMIT_NORMAL;
    c.coast_outpost  = RST_COAST_LIMIT_OUTPOST;
    c.lin_speed      = RST_MAX_LINEAR_SPEED;
    c.ang_speed      = RST_MAX_ANGULAR_SPEED;
    c.fail_rate_max  = RST_MAX_FAIL_RATE;
    c.window         = RST_FAIL_WINDOW_SIZE;
    return c;
  endfunction

  // Advance the track by one camera frame and return the beat it should produce
  function automatic tccg_result_t advance_track(input frame_t f);
    tccg_result_t r;
    logic init_rej;
    logic pred_allowed;
    longint vx, vy, w, speed_sq, limit_sq;
    r = '0;
    if (trk_state != ST_LOST && f.frame_gap_large) trk_state = ST_LOST;
    init_rej = (trk_state == ST_DETECTING) && !f.match_found;

    case (trk_state)
      ST_LOST: begin
        if (f.match_found) begin
          trk_state = ST_DETECTING;
          detect_cnt = 8'd1;
        end
      end
      ST_DETECTING: begin
        if (f.match_found) begin
          if (detect_cnt < DETECT_MAX) detect_cnt = detect_cnt + 8'd1;
          if (detect_cnt >= model_cfg.confirm_frames) trk_state = ST_TRACKING;
        end else begin
          detect_cnt = 8'd0;
          trk_state = ST_LOST;
        end
      end
      ST_TRACKING: begin
        if (f.match_found) begin
          coast_cnt = 11'd0;
        end else begin
          coast_cnt = 11'd1;
          coast_limit_now = f.target_is_outpost ? model_cfg.coast_outpost
                                                : model_cfg.coast_normal;
          trk_state = ST_TEMP_LOST;
        end
      end
      default: begin
        if (f.match_found) begin
          coast_cnt = 11'd0;
          trk_state = ST_TRACKING;
        end else begin
          if (coast_cnt < COAST_MAX) coast_cnt = coast_cnt + 11'd1;
          coast_limit_now = f.target_is_outpost ? model_cfg.coast_outpost
                                                : model_cfg.coast_normal;
          if (coast_cnt > {1'b0, coast_limit_now}) trk_state = ST_LOST;
        end
      end
    endcase

    if (trk_state != ST_LOST && f.diverged) begin
      trk_state = ST_LOST;
    end else if (int'(f.fail_window_count) * 5 >= int'(model_cfg.window) * 2) begin
      trk_state = ST_LOST;
    end else if (trk_state == ST_TRACKING || trk_state == ST_TEMP_LOST) begin
      vx = longint'($signed(f.vel_x));
      vy = longint'($signed(f.vel_y));
      w  = longint'($signed(f.ang_vel));
      if (w < 0) w = -w;
      speed_sq = vx * vx + vy * vy;
      limit_sq = longint'(model_cfg.lin_speed) * longint'(model_cfg.lin_speed);
      pred_allowed = (trk_state == ST_TEMP_LOST) && f.predict_only;
      gate_rej = f.innovation_failed || (f.match_refused && !pred_allowed) ||
                 speed_sq > limit_sq || w > longint'(model_cfg.ang_speed) ||
                 f.fail_rate > model_cfg.fail_rate_max;
      r.target_valid = !gate_rej;
    end

    r.track_state   = trk_state;
    r.init_rejected = init_rej;
    r.gate_open     = !gate_rej;
    if (trk_state == ST_DETECTING) r.warmup_count = detect_cnt;
    else if (trk_state == ST_TRACKING) r.warmup_count = model_cfg.confirm_frames;
    else r.warmup_count = 8'd0;
    r.coast_count = coast_cnt;
    return r;
  endfunction

  function automatic frame_t quiet_frame(input logic found);
    frame_t f;
    f = '0;
    f.match_found = found;
    return f;
  endfunction

  // Random content; steady frames trip no gap, divergence or (window > 0) bad window
  function automatic frame_t rand_frame(input logic found, input logic steady);
    frame_t f;
    int s;
    int unsigned cap;
    f = '0;
    f.match_found       = found;
    f.frame_gap_large   = !steady && ($urandom_range(99) < 2);
    f.diverged          = !steady && ($urandom_range(99) < 2);
    f.target_is_outpost = 1'($urandom_range(1));
    f.innovation_failed = ($urandom_range(99) < 10);
    f.match_refused     = ($urandom_range(99) < 10);
    f.predict_only      = 1'($urandom_range(1));
    if (model_cfg.window == 8'd0) f.fail_window_count = 8'd0;
    else if (!steady && $urandom_range(99) < 4) f.fail_window_count = 8'($urandom_range(255));
    else f.fail_window_count = 8'($urandom_range((2 * int'(model_cfg.window) - 1) / 5));

    if ($urandom_range(99) < 75) begin
      s = int'(model_cfg.lin_speed) * 3 / 4;
      f.vel_x = 16'(int'($urandom_range(2 * s)) - s);
      f.vel_y = 16'(int'($urandom_range(2 * s)) - s);
    end else begin
      f.vel_x = 16'($urandom);
      f.vel_y = 16'($urandom);
    end
    if ($urandom_range(99) < 75) begin
      s = int'(model_cfg.ang_speed) * 5 / 4;
      if (s > 32767) s = 32767;
      f.ang_vel = 16'(int'($urandom_range(2 * s)) - s);
    end else begin
      f.ang_vel = 16'($urandom);
    end
    cap = int'(model_cfg.fail_rate_max) + 10;
    if (cap > 511) cap = 511;
    if ($urandom_range(99) < 80) f.fail_rate = 9'($urandom_range(cap));
    else f.fail_rate = 9'($urandom_range(511));
    return f;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatch_count < 40)
      $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_frame(input frame_t f);
    tccg_result_t expected;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected = advance_track(f);
    pending_results = {pending_results, expected};
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(negedge clk);
  endtask

  // Only called with the block idle
  task automatic write_gate_cfg(input gate_cfg_t c);
    put_reg(CFG_CONFIRM_FRAMES,      CFG_DATA_W'(c.confirm_frames));
    put_reg(CFG_COAST_LIMIT_NORMAL,  CFG_DATA_W'(c.coast_normal));
    put_reg(CFG_COAST_LIMIT_OUTPOST, CFG_DATA_W'(c.coast_outpost));
    put_reg(CFG_MAX_LINEAR_SPEED,    c.lin_speed);
    put_reg(CFG_MAX_ANGULAR_SPEED,   c.ang_speed);
    put_reg(CFG_MAX_FAIL_RATE,       CFG_DATA_W'(c.fail_rate_max));
    put_reg(CFG_FAIL_WINDOW_SIZE,    CFG_DATA_W'(c.window));
    cfg_wr_en <= 1'b0;
    model_cfg = c;
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode % 4)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
      default: begin send_gap_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  // Reset registers: confirm, every gate cause, coasting; each drop but coast expiry
  task automatic test_directed_frames();
    frame_t f;
    set_idle(0);
    send_frame(quiet_frame(1'b0));
    send_frame(quiet_frame(1'b1));
    send_frame(quiet_frame(1'b0));                 // no match while detecting
    repeat (3) send_frame(quiet_frame(1'b1));      // confirmed on the third
    f = quiet_frame(1'b1); f.vel_x = 16'h8000; f.vel_y = 16'h8000; send_frame(f);
    f = quiet_frame(1'b1); f.vel_x = -16'sd1280; send_frame(f);  // on the limit
    f = quiet_frame(1'b1); f.vel_y = 16'h7fff; send_frame(f);
    f = quiet_frame(1'b1); f.ang_vel = 16'h8000; send_frame(f);
    f = quiet_frame(1'b1); f.ang_vel = 16'd5120; send_frame(f);
    f = quiet_frame(1'b1); f.fail_rate = 9'h1ff; send_frame(f);
    f = quiet_frame(1'b1); f.fail_rate = 9'd128; send_frame(f);
    f = quiet_frame(1'b1); f.innovation_failed = 1'b1; send_frame(f);
    f = quiet_frame(1'b1); f.match_refused = 1'b1; send_frame(f);
    // coast an outpost; a rejected match passes only on prediction
    f = quiet_frame(1'b0); f.target_is_outpost = 1'b1; f.match_refused = 1'b1;
    f.predict_only = 1'b1; send_frame(f);
    f.predict_only = 1'b0; send_frame(f);
    send_frame(quiet_frame(1'b1));
    send_frame(quiet_frame(1'b0));
    f = quiet_frame(1'b0); f.frame_gap_large = 1'b1; send_frame(f);  // counts kept
    repeat (3) send_frame(quiet_frame(1'b1));
    f = quiet_frame(1'b1); f.diverged = 1'b1; send_frame(f);
    f = quiet_frame(1'b1); f.fail_window_count = 8'd7; send_frame(f);
    f = quiet_frame(1'b1); f.fail_window_count = 8'd8; send_frame(f);  // exactly 0.4
    f = quiet_frame(1'b1); f.fail_window_count = 8'hff; send_frame(f);
  endtask

  task automatic test_register_extremes();
    gate_cfg_t c;
    frame_t f;
    set_idle(1);
    drain_results();
    c = '0;
    c.window = 8'd1;
    write_gate_cfg(c);
    send_frame(quiet_frame(1'b1));                 // detecting, not compared yet
    send_frame(quiet_frame(1'b1));                 // zero confirm: tracking
    send_frame(quiet_frame(1'b1));
    f = quiet_frame(1'b1); f.vel_x = 16'd1; send_frame(f);
    send_frame(quiet_frame(1'b0));
    send_frame(quiet_frame(1'b0));                 // zero coast limit drops
    drain_results();
    c.window = 8'd0;
    write_gate_cfg(c);
    repeat (3) send_frame(quiet_frame(1'b1));      // empty window drops every frame
    drain_results();
    c.confirm_frames = 8'hff;
    c.coast_normal   = 10'h3ff;
    c.coast_outpost  = 10'h3ff;
    c.lin_speed      = 15'h7fff;
    c.ang_speed      = 15'h7fff;
    c.fail_rate_max  = 9'h1ff;
    c.window         = 8'hff;
    write_gate_cfg(c);
    repeat (4) begin
      f = quiet_frame(1'b1);
      f.vel_x = 16'h8000; f.vel_y = 16'h8000; f.ang_vel = 16'h8000;
      f.fail_window_count = 8'd101;
      send_frame(f);
    end
  endtask

  // Longest confirm, then coast up to the largest limit and past it
  task automatic test_long_coast();
    gate_cfg_t c;
    set_idle(3);
    drain_results();
    c = reset_cfg();
    c.confirm_frames = 8'hff;
    c.coast_normal   = 10'h3ff;
    c.coast_outpost  = 10'h3ff;
    write_gate_cfg(c);
    repeat (256) send_frame(rand_frame(1'b1, 1'b1));
    repeat (1026) send_frame(rand_frame(1'b0, 1'b1));
    repeat (4) send_frame(rand_frame(1'b1, 1'b1));
  endtask

  task automatic test_random_phases();
    gate_cfg_t c;
    int unsigned miss_left;
    int unsigned longest;
    logic found;
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      c.confirm_frames = 8'($urandom_range(6));
      c.coast_normal   = 10'($urandom_range(12));
      c.coast_outpost  = 10'($urandom_range(12));
      c.lin_speed      = 15'(($urandom_range(99) < 70) ? $urandom_range(4000, 256)
                                                       : $urandom_range(32767, 1));
      c.ang_speed      = 15'(($urandom_range(99) < 70) ? $urandom_range(8000, 256)
                                                       : $urandom_range(32767, 1));
      c.fail_rate_max  = 9'($urandom_range(300));
      c.window         = 8'($urandom_range(255, 5));
      write_gate_cfg(c);
      set_idle(phase);
      longest = (c.coast_normal > c.coast_outpost) ? 32'(c.coast_normal)
                                                   : 32'(c.coast_outpost);
      miss_left = 0;
      repeat (60) begin
        if (miss_left == 0 && $urandom_range(99) < 6)
          miss_left = $urandom_range(longest + 3, 1);
        if (miss_left != 0) begin
          found = 1'b0;
          miss_left--;
        end else begin
          found = ($urandom_range(99) >= 5);
        end
        send_frame(rand_frame(found, 1'b0));
      end
    end
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_result = m_axis_tdata;
      if (pending_results.size() == 0) begin
        flag_mismatch("beat with nothing pending", 32'(m_axis_tdata), 0);
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result.track_state !== want_result.track_state)
          flag_mismatch("track_state", 32'(seen_result.track_state),
                        32'(want_result.track_state));
        if (seen_result.target_valid !== want_result.target_valid)
          flag_mismatch("target_valid", 32'(seen_result.target_valid),
                        32'(want_result.target_valid));
        if (seen_result.init_rejected !== want_result.init_rejected)
          flag_mismatch("init_rejected", 32'(seen_result.init_rejected),
                        32'(want_result.init_rejected));
        if (seen_result.gate_open !== want_result.gate_open)
          flag_mismatch("gate_open", 32'(seen_result.gate_open),
                        32'(want_result.gate_open));
        if (seen_result.warmup_count !== want_result.warmup_count)
          flag_mismatch("warmup_count", 32'(seen_result.warmup_count),
                        32'(want_result.warmup_count));
        if (seen_result.coast_count !== want_result.coast_count)
          flag_mismatch("coast_count", 32'(seen_result.coast_count),
                        32'(want_result.coast_count));
      end
    end
  end

  initial begin : run_sequence
    int waited;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_CONFIRM_FRAMES;
    cfg_wr_data = '0;
    model_cfg = reset_cfg();
    trk_state = ST_LOST;
    detect_cnt = 8'd0;
    coast_cnt = 11'd0;
    coast_limit_now = RST_COAST_LIMIT_NORMAL;
    gate_rej = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_register_extremes();
    test_long_coast();
    test_random_phases();

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("beats never received", 0, pending_results.size());
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
